[hdl/blam_pkg.sv]
// ----------------------------------------------------------------------------
// blam_pkg
// Types and constants shared by the blocked layout address map.
// ----------------------------------------------------------------------------
package blam_pkg;

    localparam int unsigned MAX_DIM   = 65536;
    localparam int unsigned MAX_BLOCK = 1024;

    localparam int unsigned SIZE_W  = 17;
    localparam int unsigned BLK_W   = 11;
    localparam int unsigned COORD_W = 16;
    localparam int unsigned ELEM_W  = 16;
    localparam int unsigned IDX_W   = 32;
    localparam int unsigned OP_W    = 3;
    localparam int unsigned CIDX_W  = 3;
    localparam int unsigned LANES   = 4;
    localparam int unsigned PROD_W  = 2 * BLK_W;

    typedef enum logic [OP_W-1:0] {
        OP_PACKA_MOUTER = 3'd0,
        OP_PACKA_KOUTER = 3'd1,
        OP_RESHUF_A     = 3'd2,
        OP_PACK_B       = 3'd3,
        OP_PACK_C       = 3'd4,
        OP_UNPACK_C     = 3'd5
    } t_op;

    typedef enum logic [CIDX_W-1:0] {
        CFG_SIZE_M  = 3'd0,
        CFG_SIZE_N  = 3'd1,
        CFG_SIZE_K  = 3'd2,
        CFG_BLOCK_M = 3'd3,
        CFG_BLOCK_N = 3'd4,
        CFG_BLOCK_K = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [ELEM_W-1:0]  elem;
        logic               bad;
    } t_item;

    typedef struct packed {
        logic [SIZE_W-1:0] num;
        logic [BLK_W-1:0]  dvs;
        logic [BLK_W-1:0]  rem;
        logic [SIZE_W-1:0] quo;
    } t_lane;

endpackage

[hdl/blam_div.sv]
// ----------------------------------------------------------------------------
// blam_div
// Restoring divider pipeline, one quotient bit per stage, four lanes.
// ----------------------------------------------------------------------------
module blam_div import blam_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  t_item                  i_item,
    input  t_lane [LANES-1:0]      i_lane,
    output logic                   o_valid,
    output t_item                  o_item,
    output t_lane [LANES-1:0]      o_lane
);

    localparam int unsigned STAGES = SIZE_W;

    logic [STAGES-1:0]   r_vld;
    t_item               r_item [STAGES];
    t_lane [LANES-1:0]   r_lane [STAGES];
    t_lane [LANES-1:0]   n_lane [STAGES];

    function automatic t_lane div_step(t_lane l);
        logic [BLK_W:0] t;
        t_lane          o;
        o     = l;
        t     = {l.rem, l.num[SIZE_W-1]};
        o.num = {l.num[SIZE_W-2:0], 1'b0};
        if (t >= {1'b0, l.dvs}) begin
            o.rem = BLK_W'(t - {1'b0, l.dvs});
            o.quo = {l.quo[SIZE_W-2:0], 1'b1};
        end else begin
            o.rem = t[BLK_W-1:0];
            o.quo = {l.quo[SIZE_W-2:0], 1'b0};
        end
        return o;
    endfunction

    always_comb begin
        for (int s = 0; s < STAGES; s++) begin
            for (int l = 0; l < LANES; l++) begin
                if (s == 0) begin
                    n_lane[s][l] = div_step(i_lane[l]);
                end else begin
                    n_lane[s][l] = div_step(r_lane[s-1][l]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_item[0] <= i_item;
        for (int s = 1; s < STAGES; s++) begin
            r_item[s] <= r_item[s-1];
        end
        for (int s = 0; s < STAGES; s++) begin
            r_lane[s] <= n_lane[s];
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_item  = r_item[STAGES-1];
    assign o_lane  = r_lane[STAGES-1];

endmodule

[hdl/blocked_layout_address_map.sv]
// ----------------------------------------------------------------------------
// blocked_layout_address_map
// Maps one matrix element per cycle between column-major and blocked layouts.
// ----------------------------------------------------------------------------
// channel  direction  handshake                     payload
// item     in         start & !busy                 i_op i_row i_col i_elem_data
// result   out        o_valid (one cycle strobe)    o_src_index o_dst_index
//                                                   o_elem_out o_out_of_range
// config   in         i_cfg_valid & o_cfg_ready     i_cfg_index i_cfg_data
//
// One item per cycle; each result passes the 17-stage restoring divider and
// then three multiply/add stages.
// busy and o_cfg_ready are constant; nothing in the pipeline stalls.
// Sync active-low reset clears valid bits, loads size/block registers to 32.
// ----------------------------------------------------------------------------
module blocked_layout_address_map import blam_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OP_W-1:0]     i_op,
    input  logic [COORD_W-1:0]  i_row,
    input  logic [COORD_W-1:0]  i_col,
    input  logic [ELEM_W-1:0]   i_elem_data,
    output logic                o_valid,
    output logic [IDX_W-1:0]    o_src_index,
    output logic [IDX_W-1:0]    o_dst_index,
    output logic [ELEM_W-1:0]   o_elem_out,
    output logic                o_out_of_range,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CIDX_W-1:0]   i_cfg_index,
    input  logic [SIZE_W-1:0]   i_cfg_data
);

    localparam int unsigned LAT = SIZE_W + 3;

    logic [SIZE_W-1:0] r_size_m, r_size_n, r_size_k;
    logic [BLK_W-1:0]  r_blk_m, r_blk_n, r_blk_k;
    logic [PROD_W-1:0] r_t_vnni, r_t_tile, r_t_bnbk, r_t_bnbm;

    logic [SIZE_W-1:0] cfg_size;
    logic [BLK_W-1:0]  cfg_blk;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (i_cfg_data > SIZE_W'(MAX_DIM)) begin
            cfg_size = SIZE_W'(MAX_DIM);
        end else begin
            cfg_size = i_cfg_data;
        end
        if (i_cfg_data[BLK_W-1:0] == '0) begin
            cfg_blk = BLK_W'(1);
        end else if (i_cfg_data[BLK_W-1:0] > BLK_W'(MAX_BLOCK)) begin
            cfg_blk = BLK_W'(MAX_BLOCK);
        end else begin
            cfg_blk = i_cfg_data[BLK_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_m <= SIZE_W'(32);
            r_size_n <= SIZE_W'(32);
            r_size_k <= SIZE_W'(32);
            r_blk_m  <= BLK_W'(32);
            r_blk_n  <= BLK_W'(32);
            r_blk_k  <= BLK_W'(32);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SIZE_M:  r_size_m <= cfg_size;
                CFG_SIZE_N:  r_size_n <= cfg_size;
                CFG_SIZE_K:  r_size_k <= cfg_size;
                CFG_BLOCK_M: r_blk_m  <= cfg_blk;
                CFG_BLOCK_N: r_blk_n  <= cfg_blk;
                CFG_BLOCK_K: r_blk_k  <= cfg_blk;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_t_vnni <= {(PROD_W-1)'(r_blk_k[BLK_W-1:1] * r_blk_m), 1'b0};
        r_t_tile <= PROD_W'(r_blk_m * r_blk_k);
        r_t_bnbk <= PROD_W'(r_blk_n * r_blk_k);
        r_t_bnbm <= PROD_W'(r_blk_n * r_blk_m);
    end

    // entry: range check and divider setup
    t_item             in_item;
    t_lane [LANES-1:0] in_lane;
    logic              in_bad;

    always_comb begin
        case (i_op)
            OP_PACKA_MOUTER, OP_PACKA_KOUTER, OP_RESHUF_A:
                in_bad = ({1'b0, i_row} >= r_size_m) || ({1'b0, i_col} >= r_size_k);
            OP_PACK_B:
                in_bad = ({1'b0, i_row} >= r_size_k) || ({1'b0, i_col} >= r_size_n);
            OP_PACK_C, OP_UNPACK_C:
                in_bad = ({1'b0, i_row} >= r_size_m) || ({1'b0, i_col} >= r_size_n);
            default:
                in_bad = 1'b1;
        endcase
        in_item.op   = i_op;
        in_item.row  = i_row;
        in_item.col  = i_col;
        in_item.elem = i_elem_data;
        in_item.bad  = in_bad;
        for (int l = 0; l < LANES; l++) begin
            in_lane[l].rem = '0;
            in_lane[l].quo = '0;
        end
        in_lane[0].num = {1'b0, i_row};
        in_lane[0].dvs = (i_op == OP_PACK_B) ? r_blk_k : r_blk_m;
        in_lane[1].num = {1'b0, i_col};
        in_lane[1].dvs = (i_op <= OP_RESHUF_A) ? r_blk_k : r_blk_n;
        in_lane[2].num = r_size_m;
        in_lane[2].dvs = r_blk_m;
        in_lane[3].num = r_size_k;
        in_lane[3].dvs = r_blk_k;
    end

    logic              d_vld;
    t_item             d_item;
    t_lane [LANES-1:0] d_lane;

    blam_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_item  (in_item),
        .i_lane  (in_lane),
        .o_valid (d_vld),
        .o_item  (d_item),
        .o_lane  (d_lane)
    );

    // stage 1: block numbers, inner offsets, linear index
    logic              r1_vld, r2_vld, r3_vld;
    t_item             r1_item, r2_item;
    logic [IDX_W-1:0]  r1_pa, r1_pb, r1_lin, r1_vin, r1_oa;
    logic              r1_k0;
    logic [SIZE_W-1:0] xa, ya, na;
    logic              d_areg;

    always_comb begin
        d_areg = (d_item.op <= OP_RESHUF_A);
        xa = d_areg ? d_lane[0].quo : d_lane[1].quo;
        ya = d_areg ? d_lane[1].quo : d_lane[0].quo;
        na = (d_item.op == OP_PACK_C || d_item.op == OP_UNPACK_C) ?
             d_lane[2].quo : d_lane[3].quo;
    end

    always_ff @(posedge i_clk) begin
        r1_item <= d_item;
        r1_pa   <= IDX_W'(xa * na) + IDX_W'(ya);
        r1_pb   <= IDX_W'(d_lane[1].quo * d_lane[2].quo) + IDX_W'(d_lane[0].quo);
        r1_lin  <= IDX_W'(d_item.col * ((d_item.op == OP_PACK_B) ? r_size_k : r_size_m))
                 + IDX_W'(d_item.row);
        r1_vin  <= IDX_W'(d_lane[1].rem[BLK_W-1:1] * r_blk_m) + IDX_W'(d_lane[0].rem);
        r1_oa   <= IDX_W'(d_lane[1].rem * ((d_item.op == OP_PACK_B) ? r_blk_k : r_blk_m))
                 + IDX_W'(d_lane[0].rem);
        r1_k0   <= d_lane[1].rem[0];
    end

    // stage 2: scale block numbers by tile size
    logic [IDX_W-1:0]  r2_ma, r2_mb, r2_offa, r2_offb, r2_lin;
    logic [PROD_W-1:0] ta, tb;
    logic [IDX_W-1:0]  vnni;

    always_comb begin
        vnni = {r1_vin[IDX_W-2:0], r1_k0};
        case (r1_item.op)
            OP_PACKA_MOUTER: ta = r_t_vnni;
            OP_RESHUF_A:     ta = r_t_tile;
            OP_PACK_B:       ta = r_t_bnbk;
            default:         ta = r_t_bnbm;
        endcase
        tb = (r1_item.op == OP_RESHUF_A) ? r_t_tile : r_t_vnni;
    end

    always_ff @(posedge i_clk) begin
        r2_item <= r1_item;
        r2_ma   <= IDX_W'(r1_pa * ta);
        r2_mb   <= IDX_W'(r1_pb * tb);
        r2_offa <= (r1_item.op <= OP_RESHUF_A) ? vnni : r1_oa;
        r2_offb <= vnni;
        r2_lin  <= r1_lin;
    end

    // stage 3: final add and selection
    logic [IDX_W-1:0] ba, bb, n_src, n_dst;

    always_comb begin
        ba = r2_ma + r2_offa;
        bb = r2_mb + r2_offb;
        case (r2_item.op)
            OP_PACKA_MOUTER: begin n_src = r2_lin; n_dst = ba;     end
            OP_PACKA_KOUTER: begin n_src = r2_lin; n_dst = bb;     end
            OP_RESHUF_A:     begin n_src = bb;     n_dst = ba;     end
            OP_PACK_B:       begin n_src = r2_lin; n_dst = ba;     end
            OP_PACK_C:       begin n_src = r2_lin; n_dst = ba;     end
            OP_UNPACK_C:     begin n_src = ba;     n_dst = r2_lin; end
            default:         begin n_src = '0;     n_dst = '0;     end
        endcase
        if (r2_item.bad) begin
            n_src = '0;
            n_dst = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        o_src_index    <= n_src;
        o_dst_index    <= n_dst;
        o_elem_out     <= r2_item.elem;
        o_out_of_range <= r2_item.bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            r1_vld <= d_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    assign o_valid = r3_vld;

    a_lat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without a transaction");

    a_elem : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_elem_out == $past(i_elem_data, LAT)))
        else $error("element not passed through");

    a_bad : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_of_range) |-> (o_src_index == '0 && o_dst_index == '0))
        else $error("out of range result has nonzero index");

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives mapping requests for all six layout modes through the address map,
// predicts source and destination indices from the coordinates and the
// current size and block registers, and checks each strobed result in order.
// ----------------------------------------------------------------------------
module testbench;
    import blam_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 20;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [IDX_W-1:0]  src;
        logic [IDX_W-1:0]  dst;
        logic [ELEM_W-1:0] elem;
        logic              oor;
    } t_mapping;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [OP_W-1:0]     i_op;
    logic [COORD_W-1:0]  i_row;
    logic [COORD_W-1:0]  i_col;
    logic [ELEM_W-1:0]   i_elem_data;
    logic                o_valid;
    logic [IDX_W-1:0]    o_src_index;
    logic [IDX_W-1:0]    o_dst_index;
    logic [ELEM_W-1:0]   o_elem_out;
    logic                o_out_of_range;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CIDX_W-1:0]   i_cfg_index;
    logic [SIZE_W-1:0]   i_cfg_data;

    longint unsigned dim_m, dim_n, dim_k, blk_m, blk_n, blk_k;
    t_mapping        pending_maps[$];
    int              fail_count;
    int              cycle_count;
    int              sent_count;
    int              checked_count;
    int              gap_pct;

    blocked_layout_address_map dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic longint unsigned clip_size(logic [SIZE_W-1:0] v);
        return (v > MAX_DIM) ? MAX_DIM : v;
    endfunction

    function automatic longint unsigned clip_block(logic [SIZE_W-1:0] v);
        longint unsigned b;
        b = v[BLK_W-1:0];
        if (b == 0) return 1;
        return (b > MAX_BLOCK) ? MAX_BLOCK : b;
    endfunction

    function automatic longint unsigned tile_off(longint unsigned m2, longint unsigned k2,
                                                 longint unsigned bm);
        return (k2 / 2) * (bm * 2) + m2 * 2 + (k2 % 2);
    endfunction

    function automatic t_mapping map_element(logic [OP_W-1:0] op, logic [COORD_W-1:0] r,
                                             logic [COORD_W-1:0] c, logic [ELEM_W-1:0] e);
        t_mapping        res;
        longint unsigned src, dst, nmb, nkb, mb, m2, kb, k2, nb, n2, off, blk, tl;
        longint unsigned lin, blkd;
        logic            bad;
        src = 0;
        dst = 0;
        bad = 1'b0;
        nmb = dim_m / blk_m;
        nkb = dim_k / blk_k;
        case (op)
            OP_PACKA_MOUTER, OP_PACKA_KOUTER, OP_RESHUF_A: begin
                if (r >= dim_m || c >= dim_k) begin
                    bad = 1'b1;
                end else begin
                    mb  = r / blk_m;
                    m2  = r % blk_m;
                    kb  = c / blk_k;
                    k2  = c % blk_k;
                    off = tile_off(m2, k2, blk_m);
                    blk = (blk_k / 2) * blk_m * 2;
                    tl  = blk_m * blk_k;
                    if (op == OP_PACKA_MOUTER) begin
                        src = c * dim_m + r;
                        dst = mb * (nkb * blk) + kb * blk + off;
                    end else if (op == OP_PACKA_KOUTER) begin
                        src = c * dim_m + r;
                        dst = kb * (nmb * blk) + mb * blk + off;
                    end else begin
                        src = (kb * nmb + mb) * tl + off;
                        dst = (mb * nkb + kb) * tl + off;
                    end
                end
            end
            OP_PACK_B: begin
                if (r >= dim_k || c >= dim_n) begin
                    bad = 1'b1;
                end else begin
                    kb  = r / blk_k;
                    k2  = r % blk_k;
                    nb  = c / blk_n;
                    n2  = c % blk_n;
                    src = c * dim_k + r;
                    dst = nb * (nkb * blk_n * blk_k) + kb * (blk_n * blk_k) + n2 * blk_k + k2;
                end
            end
            OP_PACK_C, OP_UNPACK_C: begin
                if (r >= dim_m || c >= dim_n) begin
                    bad = 1'b1;
                end else begin
                    mb   = r / blk_m;
                    m2   = r % blk_m;
                    nb   = c / blk_n;
                    n2   = c % blk_n;
                    lin  = c * dim_m + r;
                    blkd = nb * (nmb * blk_n * blk_m) + mb * (blk_n * blk_m) + n2 * blk_m + m2;
                    if (op == OP_PACK_C) begin
                        src = lin;
                        dst = blkd;
                    end else begin
                        src = blkd;
                        dst = lin;
                    end
                end
            end
            default: bad = 1'b1;
        endcase
        if (bad) begin
            src = 0;
            dst = 0;
        end
        res.src  = src[IDX_W-1:0];
        res.dst  = dst[IDX_W-1:0];
        res.elem = e;
        res.oor  = bad;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_mapping want;
        if (i_rst_n && o_valid) begin
            checked_count <= checked_count + 1;
            if (pending_maps.size() == 0) begin
                $error("unexpected result src=%0h dst=%0h", o_src_index, o_dst_index);
                fail_count <= fail_count + 1;
            end else begin
                want = pending_maps.pop_front();
                if (o_src_index !== want.src) begin
                    $error("src_index expected %0h actual %0h", want.src, o_src_index);
                    fail_count <= fail_count + 1;
                end
                if (o_dst_index !== want.dst) begin
                    $error("dst_index expected %0h actual %0h", want.dst, o_dst_index);
                    fail_count <= fail_count + 1;
                end
                if (o_elem_out !== want.elem) begin
                    $error("elem_out expected %0h actual %0h", want.elem, o_elem_out);
                    fail_count <= fail_count + 1;
                end
                if (o_out_of_range !== want.oor) begin
                    $error("out_of_range expected %0b actual %0b", want.oor, o_out_of_range);
                    fail_count <= fail_count + 1;
                end
            end
        end
    end

    task automatic send_element(logic [OP_W-1:0] op, logic [COORD_W-1:0] r,
                                logic [COORD_W-1:0] c, logic [ELEM_W-1:0] e);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_op        <= op;
        i_row       <= r;
        i_col       <= c;
        i_elem_data <= e;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_maps.push_back(map_element(op, r, c, e));
        sent_count++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_maps.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [SIZE_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_SIZE_M:  dim_m = clip_size(val);
            CFG_SIZE_N:  dim_n = clip_size(val);
            CFG_SIZE_K:  dim_k = clip_size(val);
            CFG_BLOCK_M: blk_m = clip_block(val);
            CFG_BLOCK_N: blk_n = clip_block(val);
            default:     blk_k = clip_block(val);
        endcase
    endtask

    task automatic set_dims(logic [SIZE_W-1:0] sm, logic [SIZE_W-1:0] sn,
                            logic [SIZE_W-1:0] sk, logic [SIZE_W-1:0] bm,
                            logic [SIZE_W-1:0] bn, logic [SIZE_W-1:0] bk);
        drain_results();
        write_reg(CFG_SIZE_M, sm);
        write_reg(CFG_SIZE_N, sn);
        write_reg(CFG_SIZE_K, sk);
        write_reg(CFG_BLOCK_M, bm);
        write_reg(CFG_BLOCK_N, bn);
        write_reg(CFG_BLOCK_K, bk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_element(OP_PACKA_MOUTER, 16'd0, 16'd0, 16'h0000);
        send_element(OP_PACKA_KOUTER, 16'd31, 16'd31, 16'hFFFF);
        send_element(OP_RESHUF_A, 16'd5, 16'd7, 16'h1234);
        send_element(OP_PACK_B, 16'd31, 16'd0, 16'h8000);
        send_element(OP_PACK_C, 16'd0, 16'd31, 16'h7FFF);
        send_element(OP_UNPACK_C, 16'd17, 16'd9, 16'hA5A5);
        send_element(OP_PACK_C, 16'd32, 16'd0, 16'h5A5A);
        send_element(OP_PACK_B, 16'd0, 16'd32, 16'h0001);
        send_element(3'd6, 16'd1, 16'd1, 16'hBEEF);
        send_element(3'd7, 16'd0, 16'd0, 16'hCAFE);
        send_element(OP_PACKA_MOUTER, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_register_extremes();
        set_dims(17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0);
        send_element(OP_PACK_C, 16'd0, 16'd0, 16'h1111);
        send_element(OP_PACKA_MOUTER, 16'd0, 16'd0, 16'h2222);
        set_dims(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h7FF, 17'h7FF, 17'h7FF);
        send_element(OP_PACKA_MOUTER, 16'hFFFF, 16'hFFFF, 16'h3333);
        send_element(OP_PACKA_KOUTER, 16'hFFFF, 16'hFFFF, 16'h4444);
        send_element(OP_RESHUF_A, 16'hFFFF, 16'hFFFF, 16'h5555);
        send_element(OP_PACK_B, 16'hFFFF, 16'hFFFF, 16'h6666);
        send_element(OP_PACK_C, 16'hFFFF, 16'hFFFF, 16'h7777);
        send_element(OP_UNPACK_C, 16'hFFFF, 16'hFFFF, 16'h8888);
        set_dims(17'd12, 17'd10, 17'd9, 17'd5, 17'd3, 17'd3);
        send_element(OP_PACKA_MOUTER, 16'd11, 16'd8, 16'h9999);
        send_element(OP_PACK_B, 16'd8, 16'd9, 16'hAAAA);
    endtask

    task automatic test_random_mapping(int count);
        int              n;
        int              pick;
        int unsigned     rr, cc;
        longint unsigned lim_r, lim_c;
        logic [OP_W-1:0] op;
        for (n = 0; n < count; n++) begin
            if (n % 70 == 0) begin
                pick = $urandom_range(3);
                if (pick == 0)
                    set_dims(SIZE_W'($urandom_range(1, 64)), SIZE_W'($urandom_range(1, 64)),
                             SIZE_W'($urandom_range(1, 64)), SIZE_W'($urandom_range(1, 16)),
                             SIZE_W'($urandom_range(1, 16)),
                             SIZE_W'(2 * $urandom_range(1, 8)));
                else if (pick == 1)
                    set_dims(SIZE_W'($urandom_range(1024, 65536)),
                             SIZE_W'($urandom_range(1024, 65536)),
                             SIZE_W'($urandom_range(1024, 65536)),
                             SIZE_W'($urandom_range(1, 1024)),
                             SIZE_W'($urandom_range(1, 1024)),
                             SIZE_W'(2 * $urandom_range(1, 512)));
                else
                    set_dims(SIZE_W'($urandom), SIZE_W'($urandom), SIZE_W'($urandom),
                             SIZE_W'($urandom), SIZE_W'($urandom), SIZE_W'($urandom));
            end
            op = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
            lim_r = (op == OP_PACK_B) ? dim_k : dim_m;
            lim_c = (op <= OP_RESHUF_A) ? dim_k : dim_n;
            if ($urandom_range(9) == 0 || lim_r == 0 || lim_c == 0) begin
                rr = $urandom_range(16'hFFFF);
                cc = $urandom_range(16'hFFFF);
            end else begin
                rr = $urandom_range(32'(lim_r - 1));
                cc = $urandom_range(32'(lim_c - 1));
            end
            send_element(op, rr[COORD_W-1:0], cc[COORD_W-1:0], 16'($urandom));
        end
    endtask

    initial begin
        cycle_count   = 0;
        fail_count    = 0;
        sent_count    = 0;
        checked_count = 0;
        gap_pct       = 31;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_op          = '0;
        i_row         = '0;
        i_col         = '0;
        i_elem_data   = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        dim_m = 32; dim_n = 32; dim_k = 32;
        blk_m = 32; blk_n = 32; blk_k = 32;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_register_extremes();
        test_random_mapping(220);
        gap_pct = 86;
        test_random_mapping(210);
        gap_pct = 0;
        test_random_mapping(220);
        drain_results();
        $display("covered %0d mappings over six modes, invalid modes and range edges", sent_count);
        $display("checked %0d results across random and extreme register settings", checked_count);
        if (fail_count == 0 && pending_maps.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
